// ----- sv/gdfc_pkg.sv -----
// shared constants and the map memory request type for the footprint checker
package gdfc_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 31;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int DIM_W   = 9;
  localparam int RAD_W   = 5;
  localparam int COORD_W = 11;
  localparam int PIX_W   = 8;
  localparam int COUNT_W = 17;

  localparam logic [PIX_W-1:0] FREE_LEVEL = 8'd127;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

endpackage

// ----- sv/gdfc_map_ram.sv -----
// occupancy map storage: one write port, one read port with registered data
module gdfc_map_ram
  import gdfc_pkg::*;
(
  input  logic             clk,
  input  ram_req_t         req,
  output logic [PIX_W-1:0] rd_data
);

  logic [PIX_W-1:0] mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ----- sv/grid_disk_footprint_check.sv -----
// Occupancy grid footprint checker. A command is taken when start is high and busy is low; every
// command gives exactly one result word, shown for one cycle with done high and never held off.
// A write (or an unused command) answers in the cycle after it is taken. A footprint query walks the
// (2r+1)^2 cells around the centre, one map read per cycle, and answers after the last cell,
// sooner once a blocked or off-map cell is found. A count walks the whole map in use and
// answers after the last cell, or in the cycle after it is taken on an empty map.
// The single read port of the map memory sets the pace of both walks. Map cells must be written
// before a query or count reads them; the map has no reset of its own.
module grid_disk_footprint_check
  import gdfc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                command,
  input  logic signed [COORD_W-1:0] cell_x,
  input  logic signed [COORD_W-1:0] cell_y,
  input  logic [PIX_W-1:0]          pixel_value,
  // result channel
  output logic                      done,
  output logic                      footprint_free,
  output logic [COUNT_W-1:0]        obstacle_count,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_COUNT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_RADIUS     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  // configuration registers
  logic [DIM_W-1:0] map_width;
  logic [DIM_W-1:0] map_height;
  logic [RAD_W-1:0] radius_cells;

  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic [RAD_W-1:0] eff_r;
  logic [DIM_W-1:0] w_m1;
  logic [DIM_W-1:0] h_m1;

  // walk state
  state_t                     state;
  logic                       walk_count;
  logic signed [COORD_W-1:0]  cx;
  logic signed [COORD_W-1:0]  cy;
  logic signed [RAD_W:0]      rad;
  logic [2*RAD_W:0]           r2;
  logic signed [RAD_W:0]      dx;
  logic signed [RAD_W:0]      dy;
  logic [COL_W-1:0]           col;
  logic [ROW_W-1:0]           row;
  logic                       fail;
  logic [COUNT_W-1:0]         count_acc;

  // read stage
  logic s1_valid;
  logic s1_check;
  logic s1_bad;

  cmd_t                       cmd_in;
  logic signed [RAD_W:0]      rad_in;
  logic signed [COORD_W:0]    px;
  logic signed [COORD_W:0]    py;
  logic signed [2*RAD_W+1:0]  dx_sq;
  logic signed [2*RAD_W+1:0]  dy_sq;
  logic [2*RAD_W+1:0]         dsq;
  logic                       in_disc;
  logic                       in_map;
  logic                       last_q;
  logic                       last_c;
  logic                       in_storage;
  logic                       fail_now;
  logic                       hit_now;
  logic [PIX_W-1:0]           rd_data;
  ram_req_t                   ram_req;

  assign pready = 1'b1;
  assign busy   = (state != ST_IDLE);
  assign cmd_in = cmd_t'(command);

  // oversized register values saturate to the storage limits
  assign eff_w = (map_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : map_width;
  assign eff_h = (map_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : map_height;
  assign eff_r = (radius_cells > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_cells;
  assign w_m1  = eff_w - DIM_W'(1);
  assign h_m1  = eff_h - DIM_W'(1);
  assign rad_in = $signed({1'b0, eff_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width    <= DIM_W'(256);
      map_height   <= DIM_W'(256);
      radius_cells <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_MAP_WIDTH:  map_width    <= pwdata[DIM_W-1:0];
        REG_MAP_HEIGHT: map_height   <= pwdata[DIM_W-1:0];
        REG_RADIUS:     radius_cells <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[3:2]))
      REG_MAP_WIDTH:  prdata = 32'(map_width);
      REG_MAP_HEIGHT: prdata = 32'(map_height);
      REG_RADIUS:     prdata = 32'(radius_cells);
      default:        prdata = '0;
    endcase
  end

  // cell under the walk pointer
  always_comb begin
    px      = {cx[COORD_W-1], cx} + (COORD_W+1)'(dx);
    py      = {cy[COORD_W-1], cy} + (COORD_W+1)'(dy);
    dx_sq   = dx * dx;
    dy_sq   = dy * dy;
    dsq     = $unsigned(dx_sq) + $unsigned(dy_sq);
    in_disc = (dsq <= (2*RAD_W+2)'(r2));
    in_map  = !px[COORD_W] && ($unsigned(px) < (COORD_W+1)'(eff_w)) &&
              !py[COORD_W] && ($unsigned(py) < (COORD_W+1)'(eff_h));
    last_q  = (dx == rad) && (dy == rad);
    last_c  = (col == w_m1[COL_W-1:0]) && (row == h_m1[ROW_W-1:0]);
  end

  assign in_storage = !cell_x[COORD_W-1] && ($unsigned(cell_x) < COORD_W'(MAX_WIDTH)) &&
                      !cell_y[COORD_W-1] && ($unsigned(cell_y) < COORD_W'(MAX_HEIGHT));

  always_comb begin
    ram_req.wr_en   = start && !busy && (cmd_in == CMD_WRITE) && in_storage;
    ram_req.wr_addr = {cell_y[ROW_W-1:0], cell_x[COL_W-1:0]};
    ram_req.wr_data = pixel_value;
    ram_req.rd_en   = (state == ST_WALK);
    ram_req.rd_addr = walk_count ? {row, col} : {py[ROW_W-1:0], px[COL_W-1:0]};
  end

  gdfc_map_ram u_map (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // evaluation of the word read in the previous cycle
  assign fail_now = s1_valid && (s1_bad || (s1_check && (rd_data < FREE_LEVEL)));
  assign hit_now  = s1_valid && (rd_data < FREE_LEVEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      done           <= 1'b0;
      footprint_free <= 1'b0;
      obstacle_count <= '0;
      s1_valid       <= 1'b0;
      fail           <= 1'b0;
      walk_count     <= 1'b0;
    end else begin
      done           <= 1'b0;
      footprint_free <= 1'b0;
      obstacle_count <= '0;
      s1_valid       <= 1'b0;
      s1_check       <= walk_count || (in_disc && in_map);
      s1_bad         <= !walk_count && in_disc && !in_map;

      if (state != ST_IDLE) begin
        if (walk_count) begin
          count_acc <= count_acc + COUNT_W'(hit_now);
        end else begin
          fail <= fail || fail_now;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            priority case (cmd_in)
              CMD_QUERY: begin
                cx         <= cell_x;
                cy         <= cell_y;
                rad        <= rad_in;
                r2         <= (2*RAD_W+1)'({6'b0, eff_r} * {6'b0, eff_r});
                dx         <= -rad_in;
                dy         <= -rad_in;
                fail       <= 1'b0;
                walk_count <= 1'b0;
                state      <= ST_WALK;
              end
              CMD_COUNT: begin
                if (eff_w == '0 || eff_h == '0) begin
                  done <= 1'b1;
                end else begin
                  col        <= '0;
                  row        <= '0;
                  count_acc  <= '0;
                  walk_count <= 1'b1;
                  state      <= ST_WALK;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        ST_WALK: begin
          if (!walk_count && (fail || fail_now)) begin
            // early out: a blocked or off-map cell settles the query
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            s1_valid <= 1'b1;
            if (walk_count) begin
              if (col == w_m1[COL_W-1:0]) begin
                col <= '0;
                row <= row + ROW_W'(1);
              end else begin
                col <= col + COL_W'(1);
              end
              if (last_c) begin
                state <= ST_DRAIN;
              end
            end else begin
              if (dy == rad) begin
                dy <= -rad;
                dx <= dx + (RAD_W+1)'(1);
              end else begin
                dy <= dy + (RAD_W+1)'(1);
              end
              if (last_q) begin
                state <= ST_DRAIN;
              end
            end
          end
        end
        ST_DRAIN: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (walk_count) begin
            obstacle_count <= count_acc + COUNT_W'(hit_now);
          end else begin
            footprint_free <= !(fail || fail_now);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word shown while a command is still in progress");

  a_write_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd_in == CMD_WRITE) |=>
      (done && !footprint_free && obstacle_count == '0))
    else $error("write command did not answer in the next cycle");

  a_quiet_outputs: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!footprint_free && obstacle_count == '0))
    else $error("result fields active without done");

  a_one_field: assert property (@(posedge clk) disable iff (rst)
    done |-> !(footprint_free && obstacle_count != '0))
    else $error("query and count fields both set");

endmodule

// ----- tb/tb_grid_disk_footprint_check.sv -----
// testbench for the occupancy grid disc footprint checker: directed and random commands
module tb_grid_disk_footprint_check;
  import gdfc_pkg::*;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_COUNT  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [3:0] ADDR_WIDTH  = 4'h0;
  localparam logic [3:0] ADDR_HEIGHT = 4'h4;
  localparam logic [3:0] ADDR_RADIUS = 4'h8;

  localparam int CYCLE_LIMIT      = 12_000_000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int RANDOM_PHASES    = 8;
  localparam int WORDS_PER_PHASE  = 40;
  localparam int FILL_SIZE        = 12;

  typedef struct packed {
    logic               free;
    logic [COUNT_W-1:0] count;
  } answer_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start;
  logic                      busy;
  logic [1:0]                command;
  logic signed [COORD_W-1:0] cell_x;
  logic signed [COORD_W-1:0] cell_y;
  logic [PIX_W-1:0]          pixel_value;
  logic                      done;
  logic                      footprint_free;
  logic [COUNT_W-1:0]        obstacle_count;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [3:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  // own copy of the grid and the registers
  logic [PIX_W-1:0] grid_cells [MAP_DEPTH];
  logic [DIM_W-1:0] width_reg  = 9'd256;
  logic [DIM_W-1:0] height_reg = 9'd256;
  logic [RAD_W-1:0] radius_reg = 5'd0;

  answer_t     awaited_answers [$];
  int          mismatches = 0;
  int unsigned cycles = 0;

  grid_disk_footprint_check u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .pixel_value   (pixel_value),
    .done          (done),
    .footprint_free(footprint_free),
    .obstacle_count(obstacle_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int used_width();
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int used_height();
    return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
  endfunction

  function automatic int used_radius();
    return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
  endfunction

  function automatic logic disc_is_free(int cx, int cy);
    int r;
    int w;
    int h;
    int x;
    int y;
    r = used_radius();
    w = used_width();
    h = used_height();
    for (int dx = -r; dx <= r; dx++) begin
      for (int dy = -r; dy <= r; dy++) begin
        if (dx * dx + dy * dy > r * r) continue;
        x = cx + dx;
        y = cy + dy;
        if (x < 0 || x >= w || y < 0 || y >= h) return 1'b0;
        if (grid_cells[y * MAX_WIDTH + x] < FREE_LEVEL) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [COUNT_W-1:0] obstacles_in_map();
    int n;
    n = 0;
    for (int y = 0; y < used_height(); y++) begin
      for (int x = 0; x < used_width(); x++) begin
        if (grid_cells[y * MAX_WIDTH + x] < FREE_LEVEL) n++;
      end
    end
    return n[COUNT_W-1:0];
  endfunction

  // mostly free grey levels, some obstacles, some right at the threshold
  function automatic int grey_level();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(127, 255);
    if (roll < 95) return $urandom_range(0, 126);
    return $urandom_range(126, 127);
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (awaited_answers.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected result word: free %0d count %0d", footprint_free, obstacle_count);
      end else begin
        want = awaited_answers.pop_front();
        if (footprint_free !== want.free || obstacle_count !== want.count) begin
          mismatches = mismatches + 1;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("result mismatch: free exp %0d got %0d, count exp %0d got %0d",
                     want.free, footprint_free, want.count, obstacle_count);
        end
      end
    end
  end

  // start is left high; the next call either raises it again or lowers it
  task automatic send_command(logic [1:0] cmd, int cx, int cy, int pix);
    answer_t answer;
    @(negedge clk);
    start       <= 1'b1;
    command     <= cmd;
    cell_x      <= cx[COORD_W-1:0];
    cell_y      <= cy[COORD_W-1:0];
    pixel_value <= pix[PIX_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    answer = '0;
    case (cmd)
      CMD_WRITE: begin
        if (cx >= 0 && cx < MAX_WIDTH && cy >= 0 && cy < MAX_HEIGHT)
          grid_cells[cy * MAX_WIDTH + cx] = pix[PIX_W-1:0];
      end
      CMD_QUERY: answer.free = disc_is_free(cx, cy);
      CMD_COUNT: answer.count = obstacles_in_map();
      default: ;
    endcase
    awaited_answers.push_back(answer);
  endtask

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      start       <= 1'b0;
      command     <= 2'($urandom);
      cell_x      <= COORD_W'($urandom);
      cell_y      <= COORD_W'($urandom);
      pixel_value <= PIX_W'($urandom);
    end
  endtask

  task automatic wait_for_answers();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_answers.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_register(logic [3:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (addr)
      ADDR_WIDTH:  width_reg  = data[DIM_W-1:0];
      ADDR_HEIGHT: height_reg = data[DIM_W-1:0];
      ADDR_RADIUS: radius_reg = data[RAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // unused upper bits of each register word carry noise
  task automatic configure_map(int w, int h, int r);
    wait_for_answers();
    write_register(ADDR_WIDTH,  ($urandom & ~32'h1ff) | (w & 32'h1ff));
    write_register(ADDR_HEIGHT, ($urandom & ~32'h1ff) | (h & 32'h1ff));
    write_register(ADDR_RADIUS, ($urandom & ~32'h1f) | (r & 32'h1f));
  endtask

  // the corner block that most maps in use are kept within gets written first
  task automatic test_fill_map();
    for (int y = 0; y < FILL_SIZE; y++) begin
      for (int x = 0; x < FILL_SIZE; x++) send_command(CMD_WRITE, x, y, grey_level());
    end
    wait_for_answers();
  endtask

  task automatic test_write_edges();
    send_command(CMD_WRITE, 0, 0, 255);
    send_command(CMD_WRITE, 255, 255, 0);
    send_command(CMD_WRITE, 255, 0, 126);
    send_command(CMD_WRITE, 0, 255, 127);
    // outside storage: dropped
    send_command(CMD_WRITE, -1024, -1024, 0);
    send_command(CMD_WRITE, 1023, 1023, 0);
    send_command(CMD_WRITE, 256, 3, 0);
    send_command(CMD_WRITE, 3, 256, 0);
    send_command(CMD_WRITE, -1, 0, 0);
    send_command(CMD_UNUSED, 1023, -1024, 255);
    wait_for_answers();
  endtask

  task automatic test_query_edges();
    send_command(CMD_QUERY, 0, 0, 0);
    send_command(CMD_QUERY, 255, 255, 0);
    send_command(CMD_QUERY, 255, 0, 255);
    send_command(CMD_QUERY, 0, 255, 0);
    send_command(CMD_QUERY, -1, 0, 0);
    send_command(CMD_QUERY, 256, 0, 0);
    send_command(CMD_QUERY, 1023, -1024, 0);
    configure_map(FILL_SIZE, FILL_SIZE, 5);
    send_command(CMD_QUERY, 5, 5, 0);
    send_command(CMD_QUERY, 6, 6, 0);
    send_command(CMD_QUERY, 4, 6, 0);
    send_command(CMD_COUNT, 0, 0, 0);
    configure_map(FILL_SIZE, FILL_SIZE, 31);
    send_command(CMD_QUERY, 6, 6, 0);
    wait_for_answers();
  endtask

  task automatic test_register_extremes();
    // empty map in either direction
    configure_map(0, 256, 5);
    send_command(CMD_QUERY, 10, 10, 0);
    send_command(CMD_COUNT, 0, 0, 0);
    configure_map(256, 0, 0);
    send_command(CMD_QUERY, 0, 0, 0);
    send_command(CMD_COUNT, 0, 0, 0);
    // oversized sizes saturate to the storage size; thin maps keep reads on written cells
    send_command(CMD_WRITE, 255, 0, 200);
    send_command(CMD_WRITE, 0, 255, 200);
    configure_map(511, 1, 0);
    send_command(CMD_QUERY, 255, 0, 0);
    send_command(CMD_QUERY, 256, 0, 0);
    configure_map(1, 511, 31);
    send_command(CMD_QUERY, 0, 300, 0);
    configure_map(1, 511, 0);
    send_command(CMD_QUERY, 0, 255, 0);
    send_command(CMD_QUERY, 0, 256, 0);
    configure_map(1, 1, 0);
    send_command(CMD_QUERY, 0, 0, 0);
    send_command(CMD_COUNT, 0, 0, 0);
    send_command(CMD_QUERY, 1, 0, 0);
    wait_for_answers();
  endtask

  task automatic test_random_phases();
    int w;
    int h;
    int r;
    int idle_pct;
    int roll;
    int ew;
    int eh;
    int cx;
    int cy;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin w = 1; h = 1; r = 0; end
        1: begin w = FILL_SIZE; h = FILL_SIZE; r = 31; end
        2: begin w = 0; h = $urandom_range(0, 511); r = $urandom_range(0, 31); end
        3: begin w = $urandom_range(1, 64); h = 0; r = $urandom_range(0, 31); end
        default: begin
          w = $urandom_range(1, FILL_SIZE);
          h = $urandom_range(1, FILL_SIZE);
          r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
        end
      endcase
      configure_map(w, h, r);
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 49 : 37);
      ew = used_width();
      eh = used_height();
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 6));
        if ($urandom_range(0, 49) == 0) wait_for_answers();
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          cx = $urandom_range(0, ((ew > 0) ? ew : MAX_WIDTH) - 1);
          cy = $urandom_range(0, ((eh > 0) ? eh : MAX_HEIGHT) - 1);
          send_command(CMD_WRITE, cx, cy, grey_level());
        end else if (roll < 42) begin
          send_command(CMD_WRITE, any_coord(), any_coord(), $urandom_range(0, 255));
        end else if (roll < 85) begin
          if ($urandom_range(0, 99) < 60 && ew > 2 * r && eh > 2 * r) begin
            cx = $urandom_range(r, ew - 1 - r);
            cy = $urandom_range(r, eh - 1 - r);
          end else begin
            cx = int'($urandom_range(0, ew + 2 * r + 3)) - (r + 2);
            cy = int'($urandom_range(0, eh + 2 * r + 3)) - (r + 2);
          end
          send_command(CMD_QUERY, cx, cy, $urandom_range(0, 255));
        end else if (roll < 93) begin
          send_command(CMD_COUNT, any_coord(), any_coord(), $urandom_range(0, 255));
        end else if (roll < 97) begin
          send_command(CMD_QUERY, any_coord(), any_coord(), $urandom_range(0, 255));
        end else begin
          send_command(CMD_UNUSED, any_coord(), any_coord(), $urandom_range(0, 255));
        end
      end
      wait_for_answers();
    end
  endtask

  initial begin
    start       = 1'b0;
    command     = CMD_WRITE;
    cell_x      = '0;
    cell_y      = '0;
    pixel_value = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = ADDR_WIDTH;
    pwdata      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_fill_map();
    test_write_edges();
    test_query_edges();
    test_register_extremes();
    test_random_phases();
    wait_for_answers();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
